>>> design/owrb_pkg.sv
// Shared types, operation codes and default sizes of the overwriting ring buffer.
package owrb_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int PATTERN_MAX_DEF = 8;

    localparam int CAP_W     = 7;
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int PLEN_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDATA,
        S_SCAN,
        S_DONE
    } t_state;

    // Control from the sequencer to the pattern matcher.
    typedef struct packed {
        logic clr;
        logic shift;
    } t_match_ctl;

endpackage

>>> design/owrb_store.sv
// Byte store: one write port and one read port with registered read data.
module owrb_store
    import owrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/owrb_matcher.sv
// Sliding window of the most recent stored bytes, compared against the search pattern.
module owrb_matcher
    import owrb_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_match_ctl           i_ctl,
    input  logic [BYTE_W-1:0]    i_byte,
    input  logic [PATTERN_W-1:0] i_pattern,
    input  logic [LW-1:0]        i_len,
    output logic                 o_hit
);

    // Entry 0 holds the newest byte.
    logic [BYTE_W-1:0] r_win [PATTERN_MAX];
    logic [LW-1:0]     r_depth;
    logic [PATTERN_MAX:0] len_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win[0] <= i_byte;
            for (int k = 1; k < PATTERN_MAX; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_depth <= '0;
        end else if (i_ctl.shift && (int'(r_depth) < PATTERN_MAX)) begin
            r_depth <= r_depth + LW'(1);
        end
    end

    // For each pattern length n, the oldest of the n newest bytes compares with pattern byte 0.
    always_comb begin
        len_ok    = '0;
        len_ok[0] = 1'b0;
        for (int n = 1; n <= PATTERN_MAX; n++) begin
            len_ok[n] = 1'b1;
            for (int j = 0; j < n; j++) begin
                if (r_win[n-1-j] != i_pattern[BYTE_W*j +: BYTE_W]) begin
                    len_ok[n] = 1'b0;
                end
            end
        end
    end

    assign o_hit = (r_depth >= i_len) && len_ok[i_len];

endmodule

>>> design/overwrite_ring_buffer_with_search_core.sv
// Top level of the overwriting ring buffer with pattern search.
//
// Byte FIFO of DEPTH slots, of which the capacity register puts 1..DEPTH in use; a write
// to a full buffer replaces the oldest byte, and writing the capacity register also
// empties the buffer. One request is handled at a time and gives one result. Write,
// clear, a read of an empty buffer and a search that cannot match (empty pattern or
// pattern longer than the fill count) go straight to the result state; a read passes
// through the read-data state, and any other search scans the stored bytes, which stream
// out of the single read port of the byte store one per cycle from the oldest on; a match
// ends the scan early. A result that the receiver stalls holds the block until taken.
module overwrite_ring_buffer_with_search_core
    import owrb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CAP_W-1:0]     i_capacity_in_use,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [BYTE_W-1:0]    i_write_byte,
    input  logic [PATTERN_W-1:0] i_pattern_bytes,
    input  logic [PLEN_W-1:0]    i_pattern_length,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_read_byte,
    output logic                 o_read_valid,
    output logic                 o_pattern_found,
    output logic [CAP_W-1:0]     o_fill_count,
    output logic                 o_is_full,
    output logic                 o_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = $clog2(PATTERN_MAX + 1);

    t_state r_state, n_state;

    logic [CW-1:0] r_cap, n_cap;
    logic [AW-1:0] r_wpos, n_wpos;
    logic [AW-1:0] r_rpos, n_rpos;
    logic [CW-1:0] r_count, n_count;

    logic [AW-1:0] r_scan_addr, n_scan_addr;
    logic [CW-1:0] r_issued, n_issued;
    logic [CW-1:0] r_seen, n_seen;
    logic          r_rd_pend, n_rd_pend;

    logic [PATTERN_W-1:0] r_pattern, n_pattern;
    logic [LW-1:0]        r_plen, n_plen;

    logic [BYTE_W-1:0] r_rbyte, n_rbyte;
    logic              r_rvalid, n_rvalid;
    logic              r_found, n_found;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_rbyte, n_out_rbyte;
    logic              r_out_rvalid, n_out_rvalid;
    logic              r_out_found, n_out_found;
    logic [CW-1:0]     r_out_count, n_out_count;
    logic              r_out_full, n_out_full;
    logic              r_out_empty, n_out_empty;

    logic              accept;
    logic              out_free;
    logic              is_full;
    logic              is_empty;
    logic [LW-1:0]     len_sat;
    logic              no_match;
    logic              hit;
    logic              scan_done;
    logic [CW-1:0]     cap_clamped;

    logic              mem_wr;
    logic              mem_rd;
    logic [AW-1:0]     mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;
    t_match_ctl        match_ctl;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p, input logic [CW-1:0] cap);
        logic [CW-1:0] q;
        q = CW'(p) + CW'(1);
        return (q >= cap) ? '0 : AW'(q);
    endfunction

    // A capacity write takes the cycle, so no request is taken alongside it.
    assign accept   = i_in_valid && (r_state == S_IDLE) && !i_cfg_wr_en;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_full  = (r_count == r_cap);
    assign is_empty = (r_count == '0);

    always_comb begin
        if (int'(i_pattern_length) > PATTERN_MAX) begin
            len_sat = LW'(PATTERN_MAX);
        end else begin
            len_sat = LW'(i_pattern_length);
        end
    end

    assign no_match = (len_sat == '0) || (int'(len_sat) > int'(r_count));

    // Out-of-range capacity writes are pulled into 1..DEPTH.
    always_comb begin
        if (i_capacity_in_use == '0) begin
            cap_clamped = CW'(1);
        end else if (int'(i_capacity_in_use) > DEPTH) begin
            cap_clamped = CW'(DEPTH);
        end else begin
            cap_clamped = CW'(i_capacity_in_use);
        end
    end

    // All bytes have passed through the window.
    assign scan_done = (r_seen == r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_operation))
                        OP_WRITE, OP_CLEAR: n_state = S_DONE;
                        OP_READ:            n_state = is_empty ? S_DONE : S_RDATA;
                        OP_SEARCH:          n_state = no_match ? S_DONE : S_SCAN;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_RDATA: n_state = S_DONE;
            S_SCAN: begin
                if (hit || scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control per state.
    always_comb begin
        n_cap        = r_cap;
        n_wpos       = r_wpos;
        n_rpos       = r_rpos;
        n_count      = r_count;
        n_scan_addr  = r_scan_addr;
        n_issued     = r_issued;
        n_seen       = r_seen;
        n_rd_pend    = 1'b0;
        n_pattern    = r_pattern;
        n_plen       = r_plen;
        n_rbyte      = r_rbyte;
        n_rvalid     = r_rvalid;
        n_found      = r_found;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_rbyte  = r_out_rbyte;
        n_out_rvalid = r_out_rvalid;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        n_out_full   = r_out_full;
        n_out_empty  = r_out_empty;
        mem_wr       = 1'b0;
        mem_rd       = 1'b0;
        mem_rd_addr  = r_rpos;
        match_ctl    = '{clr: 1'b0, shift: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_wr_en) begin
                    n_cap   = cap_clamped;
                    n_wpos  = '0;
                    n_rpos  = '0;
                    n_count = '0;
                end else if (accept) begin
                    n_rbyte   = '0;
                    n_rvalid  = 1'b0;
                    n_found   = 1'b0;
                    n_pattern = i_pattern_bytes;
                    n_plen    = len_sat;
                    unique case (t_op'(i_operation))
                        OP_WRITE: begin
                            mem_wr = 1'b1;
                            n_wpos = f_next(r_wpos, r_cap);
                            if (is_full) begin
                                n_rpos = f_next(r_rpos, r_cap);
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_READ: begin
                            if (!is_empty) begin
                                mem_rd  = 1'b1;
                                n_rpos  = f_next(r_rpos, r_cap);
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_wpos  = '0;
                            n_rpos  = '0;
                            n_count = '0;
                        end
                        OP_SEARCH: begin
                            n_scan_addr   = r_rpos;
                            n_issued      = '0;
                            n_seen        = '0;
                            match_ctl.clr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDATA: begin
                n_rbyte  = mem_rd_data;
                n_rvalid = 1'b1;
            end
            S_SCAN: begin
                // Each read is issued in the cycle before the window shifts in its byte.
                if (r_issued != r_count) begin
                    mem_rd      = 1'b1;
                    mem_rd_addr = r_scan_addr;
                    n_scan_addr = f_next(r_scan_addr, r_cap);
                    n_issued    = r_issued + CW'(1);
                    n_rd_pend   = 1'b1;
                end
                if (r_rd_pend) begin
                    match_ctl.shift = 1'b1;
                    n_seen          = r_seen + CW'(1);
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_wpos  = '0;
                    n_rpos  = '0;
                    n_count = '0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_rbyte  = r_rbyte;
                    n_out_rvalid = r_rvalid;
                    n_out_found  = r_found;
                    n_out_count  = r_count;
                    n_out_full   = is_full;
                    n_out_empty  = is_empty;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CW'(DEPTH);
            r_wpos      <= '0;
            r_rpos      <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_wpos      <= n_wpos;
            r_rpos      <= n_rpos;
            r_count     <= n_count;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_addr  <= n_scan_addr;
        r_issued     <= n_issued;
        r_seen       <= n_seen;
        r_pattern    <= n_pattern;
        r_plen       <= n_plen;
        r_rbyte      <= n_rbyte;
        r_rvalid     <= n_rvalid;
        r_found      <= n_found;
        r_out_rbyte  <= n_out_rbyte;
        r_out_rvalid <= n_out_rvalid;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
        r_out_full   <= n_out_full;
        r_out_empty  <= n_out_empty;
    end

    owrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_wpos),
        .i_wr_data (i_write_byte),
        .i_rd_en   (mem_rd),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    owrb_matcher #(
        .PATTERN_MAX (PATTERN_MAX),
        .LW          (LW)
    ) u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (match_ctl),
        .i_byte    (mem_rd_data),
        .i_pattern (r_pattern),
        .i_len     (r_plen),
        .o_hit     (hit)
    );

    assign o_in_stall      = (r_state != S_IDLE) || i_cfg_wr_en;
    assign o_out_valid     = r_out_valid;
    assign o_read_byte     = r_out_rbyte;
    assign o_read_valid    = r_out_rvalid;
    assign o_pattern_found = r_out_found;
    assign o_fill_count    = CAP_W'(r_out_count);
    assign o_is_full       = r_out_full;
    assign o_is_empty      = r_out_empty;

endmodule
